// ----- sv/upe_pkg.sv -----
// upe_pkg: shared types, character constants and the hex digit function
// for the url percent encoder. Used by every module of the block; has no
// dependencies of its own.
package upe_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // byte codes that the classifier looks for
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic       esc;   // 1: emit percent and two hex digits
        logic [7:0] code;  // pass character, or the raw byte when escaped
    } entry_t;

    // which character of an item the back end emits next
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_HIGH,
        PH_LOW
    } phase_t;

    // upper-case ascii hex digit for one nibble
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10)
            hex_char = CH_DIGIT_0[6:0] + ext;
        else
            hex_char = CH_UPPER_A[6:0] + ext - 7'd10;
    endfunction

endpackage

// ----- sv/upe_front.sv -----
// upe_front: holds the mode register, accepts input bytes and classifies
// each one into a pass character or an escape before queueing it.
// Depends on upe_pkg.
module upe_front (
    input  logic             clk,
    input  logic             rst_n,
    // configuration write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    // input byte channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    // towards the queue
    input  logic             q_full,
    output logic             q_push,
    output upe_pkg::entry_t  q_entry
);

    logic path_mode_reg;
    logic path_mode_next;
    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic keep_always;

    // mode register, always ready for a transfer
    assign cfg_ready      = 1'b1;
    assign path_mode_next = (cfg_valid && cfg_ready) ? cfg_data : path_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            path_mode_reg <= 1'b0;
        else
            path_mode_reg <= path_mode_next;
    end

    // input transfer whenever the queue has room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // character classes
    assign is_digit = (in_byte >= upe_pkg::CH_DIGIT_0) && (in_byte <= upe_pkg::CH_DIGIT_9);
    assign is_upper = (in_byte >= upe_pkg::CH_UPPER_A) && (in_byte <= upe_pkg::CH_UPPER_Z);
    assign is_lower = (in_byte >= upe_pkg::CH_LOWER_A) && (in_byte <= upe_pkg::CH_LOWER_Z);
    assign keep_always = is_digit || is_upper || is_lower
                      || (in_byte == upe_pkg::CH_DASH)
                      || (in_byte == upe_pkg::CH_UNDER)
                      || (in_byte == upe_pkg::CH_DOT);

    // pick pass character or escape
    always_comb
    begin
        q_entry.esc  = 1'b0;
        q_entry.code = in_byte;
        if (keep_always)
        begin
            q_entry.code = in_byte;
        end
        else if (!path_mode_reg && (in_byte == upe_pkg::CH_SPACE))
        begin
            q_entry.code = upe_pkg::CH_PLUS;
        end
        else if (path_mode_reg && ((in_byte == upe_pkg::CH_COLON)
                                || (in_byte == upe_pkg::CH_SLASH)))
        begin
            q_entry.code = in_byte;
        end
        else if (path_mode_reg && (in_byte == upe_pkg::CH_BACKSLASH))
        begin
            q_entry.code = upe_pkg::CH_SLASH;
        end
        else
        begin
            q_entry.esc = 1'b1;
        end
    end

endmodule

// ----- sv/upe_queue.sv -----
// upe_queue: short first-in first-out queue of classified entries between
// the front and the back end. Depends on upe_pkg.
module upe_queue #(
    parameter int DEPTH = upe_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  upe_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output upe_pkg::entry_t  head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upe_pkg::entry_t  store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = store[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- sv/upe_back.sv -----
// upe_back: takes classified queue entries and emits one output character
// per cycle into an output register while out_stall is low. Depends on upe_pkg.
module upe_back (
    input  logic             clk,
    input  logic             rst_n,
    // from the queue
    input  logic             head_valid,
    input  upe_pkg::entry_t  head_entry,
    output logic             pop,
    // output character channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [6:0]       out_char,
    output logic             last
);

    upe_pkg::phase_t phase_reg;
    upe_pkg::phase_t phase_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [6:0]      out_char_reg;
    logic [6:0]      out_char_next;
    logic            last_reg;
    logic            last_next;
    logic            load;
    logic            advance;
    logic [6:0]      sel_char;
    logic            sel_last;

    // output register is free when empty or being transferred
    assign load    = !out_valid_reg || !out_stall;
    assign advance = load && head_valid;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            upe_pkg::PH_FIRST:
                if (advance && head_entry.esc)
                    phase_next = upe_pkg::PH_HIGH;
            upe_pkg::PH_HIGH:
                if (advance)
                    phase_next = upe_pkg::PH_LOW;
            upe_pkg::PH_LOW:
                if (advance)
                    phase_next = upe_pkg::PH_FIRST;
            default:
                phase_next = upe_pkg::PH_FIRST;
        endcase
    end

    // character selection and queue pop
    always_comb
    begin
        sel_char = head_entry.code[6:0];
        sel_last = 1'b1;
        pop      = 1'b0;
        unique case (phase_reg)
            upe_pkg::PH_FIRST:
            begin
                if (head_entry.esc)
                begin
                    sel_char = upe_pkg::CH_PERCENT[6:0];
                    sel_last = 1'b0;
                end
                else
                begin
                    pop = advance;
                end
            end
            upe_pkg::PH_HIGH:
            begin
                sel_char = upe_pkg::hex_char(head_entry.code[7:4]);
                sel_last = 1'b0;
            end
            upe_pkg::PH_LOW:
            begin
                sel_char = upe_pkg::hex_char(head_entry.code[3:0]);
                pop      = advance;
            end
            default:
            begin
                sel_char = head_entry.code[6:0];
                sel_last = 1'b1;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (load)
            out_valid_next = head_valid;
        if (advance)
        begin
            out_char_next = sel_char;
            last_next     = sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= upe_pkg::PH_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// ----- sv/url_percent_encoder_top.sv -----
// url_percent_encoder_top: url percent encoder, one byte in, one to three
// ascii characters out. Instantiates upe_front, upe_queue and upe_back;
// depends on upe_pkg.
//
//  channel | signals                        | direction | transfer when
//  --------+--------------------------------+-----------+----------------------
//  config  | cfg_valid cfg_ready cfg_data   | in        | cfg_valid & cfg_ready
//  input   | in_valid in_stall in_byte      | in        | in_valid & !in_stall
//  output  | out_valid out_stall out_char   | out       | out_valid & !out_stall
//          | last                           |           |
//
// A passed byte yields one character, an escaped byte three, one per cycle
// from the back end while out_stall is low. Input bytes are taken every
// cycle while the queue of QUEUE_DEPTH entries has room. An input byte
// reaches the output through the queue write, then the output register.
// Reset clears the mode to normal, empties the queue and the output
// register. out_stall holds the output register and, once the queue
// fills, raises in_stall.
module url_percent_encoder_top #(
    parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_char,
    output logic       last
);

    upe_pkg::entry_t push_entry;
    upe_pkg::entry_t head_entry;
    logic            push;
    logic            full;
    logic            pop;
    logic            head_valid;

    // classify and accept
    upe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    // decoupling queue
    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // character emission
    upe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last       (last)
    );

endmodule
